[design/assert_macros.svh]
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while in reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, off while in reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

// Implication that is also checked during reset.
`define ASSERT_ALWAYS(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |-> (cons)) \
    else $error("assertion failed");

`endif

[design/upe_pkg.sv]
package upe_pkg;

  localparam int COUNT_BITS = 16;
  localparam int CAP_W      = 16;
  localparam int TOTAL_W    = 16;
  // compare width: room for count + 3 and for the full capacity
  localparam int CMP_W      = ((COUNT_BITS > CAP_W) ? COUNT_BITS : CAP_W) + 2;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  localparam int CFG_IDX_W  = 1;
  localparam logic [CFG_IDX_W-1:0] REG_COMPONENT_MODE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_CAPACITY   = 1'd1;

  localparam logic [7:0] CHAR_PERCENT = 8'h25;

  typedef enum logic [1:0] {
    KIND_REFUSED = 2'd0,
    KIND_LITERAL = 2'd1,
    KIND_ESCAPED = 2'd2
  } upe_kind_e;

  typedef struct packed {
    upe_kind_e             kind;
    logic [7:0]            src;
    logic [COUNT_BITS-1:0] base;  // count before this item
  } upe_entry_t;

  function automatic logic upe_passes(input logic [7:0] c, input logic comp);
    logic keep;
    begin
      keep = 1'b0;
      if ((c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A) ||
          (c >= 8'h30 && c <= 8'h39)) begin
        keep = 1'b1;
      end else begin
        case (c)
          8'h21, 8'h27, 8'h28, 8'h29, 8'h2A, 8'h2D, 8'h2E, 8'h5F, 8'h7E: keep = 1'b1;
          // reserved delimiters, kept only in full mode
          8'h23, 8'h24, 8'h26, 8'h2B, 8'h2C, 8'h2F, 8'h3A, 8'h3B, 8'h3D, 8'h3F,
          8'h40: keep = !comp;
          default: keep = 1'b0;
        endcase
      end
      return keep;
    end
  endfunction

  function automatic logic [7:0] upe_hex(input logic [3:0] n);
    begin
      return (n < 4'd10) ? (8'h30 + {4'd0, n}) : (8'h37 + {4'd0, n});
    end
  endfunction

endpackage

[design/upe_fifo.sv]
module upe_fifo import upe_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  upe_entry_t push_data_i,
  output logic       full_o,
  input  logic       pop_i,
  output logic       head_valid_o,
  output upe_entry_t head_o
);

  upe_entry_t            mem_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [FIFO_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [FIFO_CNT_W-1:0] cnt_q, cnt_d;
  logic                  do_push, do_pop;

  assign full_o       = (cnt_q == FIFO_CNT_W'(FIFO_DEPTH));
  assign head_valid_o = (cnt_q != '0);
  assign head_o       = mem_q[rd_ptr_q];

  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && head_valid_o;

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

[design/upe_front.sv]
module upe_front import upe_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CAP_W-1:0]     cfg_data_i,
  input  logic                 in_valid_i,
  input  logic [7:0]           in_byte_i,
  input  logic                 in_last_i,
  output logic                 in_ready_o,
  input  logic                 fifo_full_i,
  output logic                 push_o,
  output upe_entry_t           push_data_o
);

  localparam logic [CMP_W-1:0] CountMax = CMP_W'((64'd1 << COUNT_BITS) - 64'd1);

  logic                  comp_mode_q;
  logic [CAP_W-1:0]      capacity_q;
  logic                  halted_q, halted_d;
  logic [COUNT_BITS-1:0] count_q, count_d;

  logic [CMP_W-1:0] cap_w, limit, sum;
  logic             keep, refuse, accept;

  assign in_ready_o = !fifo_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign push_o     = accept;

  always_comb begin
    cap_w  = CMP_W'(capacity_q);
    limit  = (cap_w > CountMax) ? CountMax : cap_w;
    keep   = upe_passes(in_byte_i, comp_mode_q);
    sum    = CMP_W'(count_q) + (keep ? CMP_W'(1) : CMP_W'(3));
    refuse = halted_q || (sum > limit);

    push_data_o.src  = in_byte_i;
    push_data_o.base = count_q;
    if (refuse) begin
      push_data_o.kind = KIND_REFUSED;
    end else if (keep) begin
      push_data_o.kind = KIND_LITERAL;
    end else begin
      push_data_o.kind = KIND_ESCAPED;
    end

    halted_d = halted_q;
    count_d  = count_q;
    if (accept) begin
      if (in_last_i) begin
        halted_d = 1'b0;
        count_d  = '0;
      end else if (refuse) begin
        halted_d = 1'b1;
      end else begin
        count_d = sum[COUNT_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      comp_mode_q <= 1'b1;
      capacity_q  <= '1;
      halted_q    <= 1'b0;
      count_q     <= '0;
    end else begin
      halted_q <= halted_d;
      count_q  <= count_d;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          REG_COMPONENT_MODE: comp_mode_q <= cfg_data_i[0];
          REG_OUT_CAPACITY:   capacity_q  <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

endmodule

[design/upe_back.sv]
module upe_back import upe_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               head_valid_i,
  input  upe_entry_t         head_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [7:0]         enc_byte_o,
  output logic               byte_valid_o,
  output logic               run_last_o,
  output logic               accepted_o,
  output logic [TOTAL_W-1:0] written_total_o
);

  logic [1:0]               phase_q, phase_d;
  logic                     valid_q;
  logic [7:0]               byte_q, byte_d;
  logic                     bvalid_q, bvalid_d;
  logic                     last_q, last_d;
  logic                     acc_q, acc_d;
  logic [TOTAL_W-1:0]       total_q, total_d;
  logic [COUNT_BITS+1:0]    total_w;
  logic                     slot_free, emit;

  assign slot_free = !valid_q || out_ready_i;
  assign emit      = slot_free && head_valid_i;
  assign pop_o     = emit && last_d;

  always_comb begin
    byte_d   = '0;
    bvalid_d = 1'b0;
    last_d   = 1'b1;
    acc_d    = 1'b0;
    total_w  = (COUNT_BITS+2)'(head_i.base) + (COUNT_BITS+2)'(phase_q) + 1'b1;
    case (head_i.kind)
      KIND_REFUSED: begin
        total_w = (COUNT_BITS+2)'(head_i.base);
      end
      KIND_LITERAL: begin
        byte_d   = head_i.src;
        bvalid_d = 1'b1;
        acc_d    = 1'b1;
      end
      KIND_ESCAPED: begin
        bvalid_d = 1'b1;
        acc_d    = 1'b1;
        last_d   = (phase_q == 2'd2);
        case (phase_q)
          2'd0:    byte_d = CHAR_PERCENT;
          2'd1:    byte_d = upe_hex(head_i.src[7:4]);
          default: byte_d = upe_hex(head_i.src[3:0]);
        endcase
      end
      default: ;
    endcase
    total_d = TOTAL_W'(total_w);

    phase_d = phase_q;
    if (emit) begin
      phase_d = last_d ? 2'd0 : phase_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
      valid_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      if (slot_free) begin
        valid_q <= head_valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      byte_q   <= byte_d;
      bvalid_q <= bvalid_d;
      last_q   <= last_d;
      acc_q    <= acc_d;
      total_q  <= total_d;
    end
  end

  assign out_valid_o     = valid_q;
  assign enc_byte_o      = byte_q;
  assign byte_valid_o    = bvalid_q;
  assign run_last_o      = last_q;
  assign accepted_o      = acc_q;
  assign written_total_o = total_q;

endmodule

[design/url_percent_encoder.sv]
// Percent-encoder for text, one source byte per input item.
// Input stream: tdata[7:0] carries the source byte, tlast marks the last byte
// of a text. Output stream: one item per output character; tdata holds the
// character and the running count of characters written for the text, tuser
// flags whether a character is present and whether the source byte was taken,
// tlast marks the final output item of each source byte. A byte that does not
// fit the output capacity, or arrives after one that did not, gives a single
// refused item with no character; the text's count and halt clear after tlast.
// Config channel: index 0 selects component mode (bit 0), index 1 the output
// capacity; write only while no items are in flight. Always ready.
// The input byte is written to the queue, and each output item is registered
// in the output stage. Throughput: the output stage emits one item per cycle
// while the receiver is ready, so a kept or refused byte gives one item and an
// escaped byte three. A four-item queue between classifier and expander lets
// input keep flowing during escapes. Reset clears the queue, count and halt
// flag and sets mode 1, capacity 65535. When the receiver stalls the output
// item holds; input is taken until the queue fills.
module url_percent_encoder import upe_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CAP_W-1:0]     cfg_data_i,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [7:0]           s_axis_tdata,  // [7:0] src_byte
  input  logic                 s_axis_tlast,  // last_of_text
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [23:0]          m_axis_tdata,  // [7:0] enc_byte, [23:8] written_total
  output logic [1:0]           m_axis_tuser,  // [0] byte_valid, [1] accepted
  output logic                 m_axis_tlast   // run_last
);

  logic       fifo_full, push, pop, head_valid;
  upe_entry_t push_data, head;

  assign cfg_ready_o = 1'b1;

  upe_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (s_axis_tvalid),
    .in_byte_i   (s_axis_tdata),
    .in_last_i   (s_axis_tlast),
    .in_ready_o  (s_axis_tready),
    .fifo_full_i (fifo_full),
    .push_o      (push),
    .push_data_o (push_data)
  );

  upe_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_data_i  (push_data),
    .full_o       (fifo_full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_o       (head)
  );

  upe_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .head_valid_i    (head_valid),
    .head_i          (head),
    .pop_o           (pop),
    .out_valid_o     (m_axis_tvalid),
    .out_ready_i     (m_axis_tready),
    .enc_byte_o      (m_axis_tdata[7:0]),
    .byte_valid_o    (m_axis_tuser[0]),
    .run_last_o      (m_axis_tlast),
    .accepted_o      (m_axis_tuser[1]),
    .written_total_o (m_axis_tdata[23:8])
  );

endmodule

[design/upe_checker.sv]
`include "assert_macros.svh"

module upe_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser,
  input logic        m_axis_tlast
);

  logic        out_wait, out_refused, refused_ok, out_mid, mid_ok;
  logic [26:0] out_item;

  assign out_wait    = m_axis_tvalid && !m_axis_tready;
  assign out_item    = {m_axis_tlast, m_axis_tuser, m_axis_tdata};
  assign out_refused = m_axis_tvalid && !m_axis_tuser[1];
  assign refused_ok  = !m_axis_tuser[0] && m_axis_tlast && (m_axis_tdata[7:0] == 8'h00);
  assign out_mid     = m_axis_tvalid && !m_axis_tlast;
  assign mid_ok      = m_axis_tuser[0] && m_axis_tuser[1];

  // a stalled output item must not change
  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_wait, m_axis_tvalid && $stable(out_item))

  // refused byte: single empty item
  `ASSERT_IMPL(a_refused_shape, clk_i, rst_ni, out_refused, refused_ok)

  // only escapes span several items, and each of those carries a character
  `ASSERT_IMPL(a_mid_escape, clk_i, rst_ni, out_mid, mid_ok)

  `ASSERT_ALWAYS(a_reset_idle, clk_i, !rst_ni, !m_axis_tvalid)

endmodule

bind url_percent_encoder upe_checker u_upe_checker (.*);

[verif/url_percent_encoder_tb.sv]
`timescale 1ns / 100ps

module url_percent_encoder_tb import upe_pkg::*;;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES    = 60;
  localparam int PHASES         = 5;
  localparam int PHASE_ITEMS    = 16;

  typedef struct packed {
    logic [7:0]         ch;
    logic               present;
    logic               fin;
    logic               took;
    logic [TOTAL_W-1:0] total;
  } enc_char_t;

  typedef enum logic {ROW_BYTE, ROW_CFG} row_op_e;

  // val carries the source byte (bits 7:0) or the register data
  typedef struct packed {
    row_op_e               op;
    logic [CFG_IDX_W-1:0]  idx;
    logic [15:0]           val;
    logic                  fin;
    logic                  pinned;
    logic [7:0]            ch;
    logic                  ok;
    logic [TOTAL_W-1:0]    tot;
  } plan_row_t;

  localparam int PLAN_LEN = 25;
  localparam plan_row_t PLAN [PLAN_LEN] = '{
    // reset settings: component mode, full capacity
    '{ROW_BYTE, REG_COMPONENT_MODE, 16'h0041, 1'b0, 1'b1, 8'h41, 1'b1, 16'd1},
    '{ROW_BYTE, REG_COMPONENT_MODE, 16'h007A, 1'b0, 1'b1, 8'h7A, 1'b1, 16'd2},
    '{ROW_BYTE, REG_COMPONENT_MODE, 16'h0030, 1'b0, 1'b1, 8'h30, 1'b1, 16'd3},
    '{ROW_BYTE, REG_COMPONENT_MODE, 16'h0039, 1'b0, 1'b1, 8'h39, 1'b1, 16'd4},
    '{ROW_BYTE, REG_COMPONENT_MODE, 16'h007E, 1'b0, 1'b1, 8'h7E, 1'b1, 16'd5},
    '{ROW_BYTE, REG_COMPONENT_MODE, 16'h002F, 1'b0, 1'b0, 8'h00, 1'b0, 16'd0},
    '{ROW_BYTE, REG_COMPONENT_MODE, 16'h0000, 1'b0, 1'b0, 8'h00, 1'b0, 16'd0},
    '{ROW_BYTE, REG_COMPONENT_MODE, 16'h00FF, 1'b1, 1'b0, 8'h00, 1'b0, 16'd0},
    // full mode, capacity 4: overflow halts the text until tlast
    '{ROW_CFG,  REG_COMPONENT_MODE, 16'h0000, 1'b0, 1'b0, 8'h00, 1'b0, 16'd0},
    '{ROW_CFG,  REG_OUT_CAPACITY,   16'd4,    1'b0, 1'b0, 8'h00, 1'b0, 16'd0},
    '{ROW_BYTE, REG_COMPONENT_MODE, 16'h002F, 1'b0, 1'b1, 8'h2F, 1'b1, 16'd1},
    '{ROW_BYTE, REG_COMPONENT_MODE, 16'h0040, 1'b0, 1'b1, 8'h40, 1'b1, 16'd2},
    '{ROW_BYTE, REG_COMPONENT_MODE, 16'h0020, 1'b0, 1'b1, 8'h00, 1'b0, 16'd2},
    '{ROW_BYTE, REG_COMPONENT_MODE, 16'h0061, 1'b0, 1'b1, 8'h00, 1'b0, 16'd2},
    '{ROW_BYTE, REG_COMPONENT_MODE, 16'h0062, 1'b1, 1'b1, 8'h00, 1'b0, 16'd2},
    '{ROW_BYTE, REG_COMPONENT_MODE, 16'h0063, 1'b0, 1'b1, 8'h63, 1'b1, 16'd1},
    '{ROW_BYTE, REG_COMPONENT_MODE, 16'h0080, 1'b0, 1'b0, 8'h00, 1'b0, 16'd0},
    '{ROW_BYTE, REG_COMPONENT_MODE, 16'h0064, 1'b1, 1'b1, 8'h00, 1'b0, 16'd4},
    // zero capacity refuses everything
    '{ROW_CFG,  REG_COMPONENT_MODE, 16'h0001, 1'b0, 1'b0, 8'h00, 1'b0, 16'd0},
    '{ROW_CFG,  REG_OUT_CAPACITY,   16'd0,    1'b0, 1'b0, 8'h00, 1'b0, 16'd0},
    '{ROW_BYTE, REG_COMPONENT_MODE, 16'h0078, 1'b1, 1'b1, 8'h00, 1'b0, 16'd0},
    // capacity 1: an escape never fits, a literal does
    '{ROW_CFG,  REG_OUT_CAPACITY,   16'd1,    1'b0, 1'b0, 8'h00, 1'b0, 16'd0},
    '{ROW_BYTE, REG_COMPONENT_MODE, 16'h0025, 1'b0, 1'b1, 8'h00, 1'b0, 16'd0},
    '{ROW_BYTE, REG_COMPONENT_MODE, 16'h0071, 1'b1, 1'b1, 8'h00, 1'b0, 16'd0},
    '{ROW_BYTE, REG_COMPONENT_MODE, 16'h0071, 1'b1, 1'b1, 8'h71, 1'b1, 16'd1}
  };

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [CAP_W-1:0]     cfg_data_i;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [7:0]           s_axis_tdata;
  logic                 s_axis_tlast;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [23:0]          m_axis_tdata;
  logic [1:0]           m_axis_tuser;
  logic                 m_axis_tlast;

  // typed-in expectation for the first result of the item on the bus
  logic               pin_on;
  logic [7:0]         pin_ch;
  logic               pin_ok;
  logic [TOTAL_W-1:0] pin_total;

  // predictor state
  logic                  mode_q;
  logic [CAP_W-1:0]      capacity_q;
  logic                  halted_q;
  logic [COUNT_BITS-1:0] count_q;

  enc_char_t pending_chars[$];
  int        mismatches;
  int        stall_pending;

  string unreserved_marks = "!'()*-._~";
  string reserved_delims  = "#$&+,/:;=?@";
  string hex_digits       = "0123456789ABCDEF";

  always #10 clk_i = ~clk_i;

  url_percent_encoder dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  function automatic logic in_string(input logic [7:0] c, input string s);
    for (int i = 0; i < s.len(); i++) begin
      if (c == s[i]) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic logic keeps_char(input logic [7:0] c, input logic comp);
    if ((c >= "A" && c <= "Z") || (c >= "a" && c <= "z") || (c >= "0" && c <= "9")) begin
      return 1'b1;
    end
    if (in_string(c, unreserved_marks)) return 1'b1;
    return !comp && in_string(c, reserved_delims);
  endfunction

  task automatic note_mismatch(input string what, input enc_char_t want, input enc_char_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t %s: expected ch=%h valid=%b acc=%b last=%b total=%0d", $realtime, what,
               want.ch, want.present, want.took, want.fin, want.total);
      $display("%0t %s: got      ch=%h valid=%b acc=%b last=%b total=%0d", $realtime, what,
               got.ch, got.present, got.took, got.fin, got.total);
    end
  endtask

  // works out the characters one source byte turns into and queues them
  task automatic encode_byte(input logic [7:0] c, input logic end_of_text);
    enc_char_t res[3];
    longint    lim;
    int        need;
    int        n;
    lim  = capacity_q;
    if (lim > (longint'(1) << COUNT_BITS) - 1) lim = (longint'(1) << COUNT_BITS) - 1;
    need = keeps_char(c, mode_q) ? 1 : 3;
    if (halted_q || longint'(count_q) + need > lim) begin
      halted_q = 1'b1;
      res[0]   = '{8'h00, 1'b0, 1'b1, 1'b0, TOTAL_W'(count_q)};
      n        = 1;
    end else if (need == 1) begin
      count_q = count_q + 1'b1;
      res[0]  = '{c, 1'b1, 1'b1, 1'b1, TOTAL_W'(count_q)};
      n       = 1;
    end else begin
      res[0] = '{CHAR_PERCENT, 1'b1, 1'b0, 1'b1, TOTAL_W'(count_q + 1)};
      res[1] = '{hex_digits[c[7:4]], 1'b1, 1'b0, 1'b1, TOTAL_W'(count_q + 2)};
      res[2] = '{hex_digits[c[3:0]], 1'b1, 1'b1, 1'b1, TOTAL_W'(count_q + 3)};
      count_q = COUNT_BITS'(count_q + 3);
      n       = 3;
    end
    if (pin_on) begin
      res[0].ch      = pin_ch;
      res[0].present = pin_ok;
      res[0].took    = pin_ok;
      res[0].total   = pin_total;
    end
    for (int i = 0; i < n; i++) pending_chars.push_back(res[i]);
    if (end_of_text) begin
      halted_q = 1'b0;
      count_q  = '0;
    end
  endtask

  always @(posedge clk_i) begin : scoreboard
    enc_char_t got;
    enc_char_t want;
    if (!rst_ni) begin
      mode_q     = 1'b1;
      capacity_q = '1;
      halted_q   = 1'b0;
      count_q    = '0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == REG_COMPONENT_MODE) mode_q = cfg_data_i[0];
        else if (cfg_index_i == REG_OUT_CAPACITY) capacity_q = cfg_data_i;
      end
      if (s_axis_tvalid && s_axis_tready) encode_byte(s_axis_tdata, s_axis_tlast);
      if (m_axis_tvalid && m_axis_tready) begin
        got = '{m_axis_tdata[7:0], m_axis_tuser[0], m_axis_tlast, m_axis_tuser[1],
                m_axis_tdata[23:8]};
        if (pending_chars.size() == 0) begin
          note_mismatch("unexpected item", '0, got);
        end else begin
          want = pending_chars.pop_front();
          if (got !== want) note_mismatch("mismatch", want, got);
        end
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("*** FAILED ***");
    $finish;
  end

  function automatic int gap_length(input int longest);
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 2);
    if (r < 95) return $urandom_range(3, 6);
    return $urandom_range(10, longest);
  endfunction

  // receiver: bursts of ready, random gaps, one long hold when asked
  initial begin : receiver
    int on_left;
    int off_left;
    on_left       = 0;
    off_left      = 0;
    m_axis_tready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (stall_pending != 0 && s_axis_tvalid) begin
        stall_pending = 0;
        off_left      = HOLD_CYCLES;
        on_left       = 1;
      end
      if (off_left == 0 && on_left == 0) begin
        off_left = gap_length(40);
        on_left  = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
      end
      if (off_left > 0) begin
        m_axis_tready <= 1'b0;
        off_left--;
      end else begin
        m_axis_tready <= 1'b1;
        on_left--;
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic fin, input logic pinned,
                           input logic [7:0] ch, input logic ok, input logic [TOTAL_W-1:0] tot);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= fin;
    pin_on        <= pinned;
    pin_ch        <= ch;
    pin_ok        <= ok;
    pin_total     <= tot;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  task automatic pause_input(input int n);
    if (n > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  // wait for every queued character, then hold off for a margin
  task automatic settle_down();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_chars.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic set_register(input logic [CFG_IDX_W-1:0] idx, input logic [CAP_W-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [CAP_W-1:0] pick_capacity();
    int r;
    r = $urandom_range(0, 9);
    if (r <= 5) return CAP_W'($urandom_range(1, 24));
    if (r <= 7) return '1;
    if (r == 8) return CAP_W'(1);
    return CAP_W'($urandom_range(25, 65534));
  endfunction

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 9))
      0: return 8'("A" + $urandom_range(0, 25));
      1: return 8'("a" + $urandom_range(0, 25));
      2, 3: return 8'("0" + $urandom_range(0, 9));
      4, 5: return unreserved_marks[$urandom_range(0, unreserved_marks.len() - 1)];
      6, 7: return reserved_delims[$urandom_range(0, reserved_delims.len() - 1)];
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  initial begin : stimulus
    int sent;
    int len;
    rst_ni        <= 1'b0;
    cfg_valid_i   <= 1'b0;
    cfg_index_i   <= REG_COMPONENT_MODE;
    cfg_data_i    <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tlast  <= 1'b0;
    pin_on        <= 1'b0;
    pin_ch        <= '0;
    pin_ok        <= 1'b0;
    pin_total     <= '0;
    mismatches    = 0;
    stall_pending = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < PLAN_LEN; i++) begin
      if (PLAN[i].op == ROW_CFG) begin
        settle_down();
        set_register(PLAN[i].idx, PLAN[i].val);
      end else begin
        send_byte(PLAN[i].val[7:0], PLAN[i].fin, PLAN[i].pinned, PLAN[i].ch, PLAN[i].ok,
                  PLAN[i].tot);
        pause_input(gap_length(30));
      end
    end

    // random texts; phase 1 runs back to back into a held-off receiver
    for (int p = 0; p < PHASES; p++) begin
      settle_down();
      set_register(REG_COMPONENT_MODE, CAP_W'($urandom_range(0, 1)));
      set_register(REG_OUT_CAPACITY, pick_capacity());
      if (p == 1) stall_pending = 1;
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        len = $urandom_range(1, 10);
        if (len > PHASE_ITEMS - sent) len = PHASE_ITEMS - sent;
        for (int k = 0; k < len; k++) begin
          send_byte(pick_byte(), k == len - 1, 1'b0, 8'h00, 1'b0, '0);
          sent++;
          pause_input((p == 1) ? 0 : gap_length(30));
        end
      end
    end

    settle_down();
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
